[rtl/wavp_pkg.sv]
// Shared types and constants for the WAV PCM stream parser.
package wavp_pkg;

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_CHUNK,
		PH_FMT,
		PH_SKIP,
		PH_DIV,
		PH_DATA
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_BAD_HDR   = 3'd1,
		ST_SHORT_FMT = 3'd2,
		ST_UNSUPP    = 3'd3,
		ST_EMPTY     = 3'd4,
		ST_TRUNC     = 3'd5
	} status_t;

	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_EOF  = 1'b1;
	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	localparam logic [31:0] TAG_FMT  = 32'h666D7420;
	localparam logic [31:0] TAG_DATA = 32'h64617461;
	localparam logic [31:0] TAG_RIFF = 32'h52494646;
	localparam logic [31:0] TAG_WAVE = 32'h57415645;
	localparam logic [7:0]  PCM_OFFSET = 8'd128;
	localparam int          DIV_STEPS = 32;

	// divider request / reply
	typedef struct packed {
		logic        start;
		logic [31:0] dividend;
		logic [16:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] quotient;
	} div_rsp_t;

	// output result
	typedef struct packed {
		logic        kind;
		logic [15:0] sample;
		logic [15:0] channel_index;
		logic [15:0] channel_count;
		logic [31:0] sample_rate;
		logic [2:0]  status;
		logic        last;
	} result_t;

endpackage

[rtl/wavp_divider.sv]
// Radix-2 restoring divider, one quotient bit per cycle.
module wavp_divider (
	input  logic                clk,
	input  logic                arst_n,
	input  wavp_pkg::div_req_t  req,
	output wavp_pkg::div_rsp_t  rsp
);
	logic [31:0] quo_q;
	logic [16:0] rem_q;
	logic [16:0] dvs_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [17:0] trial;

	assign trial = {rem_q, quo_q[31]} - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'(wavp_pkg::DIV_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			if (!trial[17]) begin
				rem_q <= trial[16:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= {rem_q[15:0], quo_q[31]};
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;
endmodule

[rtl/wav_pcm_stream_parser.sv]
// Top level of the WAV PCM stream parser: byte sequencer, divider and output register.
// One file byte per transaction. A byte that makes no result does not hold off the next; a byte that
// makes a result does, since s_tready stays low while a result waits in the
// output register (the final sample waits until both of its results have been taken).
// At the end of a data chunk header the frame count is found by a bit-serial divider in
// 32 steps, and s_tready stays low while it runs.
// End of file (tuser=1) emits a final status if none was sent yet and clears the parser.
// Samples stream out as they arrive, so a nonzero status tells the consumer to discard
// the clip.
module wav_pcm_stream_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] file_byte
	input  logic        s_tuser,   // [0] opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [87:0] m_tdata,   // sample, channel_index, channel_count, sample_rate, status
	output logic        m_tuser,   // [0] kind
	output logic        m_tlast    // last
);
	wavp_pkg::phase_t   phase_q, phase_d;
	logic [3:0]  pos_q;
	logic [31:0] tag_q, len_q;
	logic [32:0] skip_q;
	logic [15:0] fmt_q, chans_q, bits_q, chan_cnt_q;
	logic [31:0] rate_q, remain_q;
	logic        fvalid_q, finished_q;
	logic [7:0]  low_q;
	// output: up to two pending results
	wavp_pkg::result_t  out0_q, out1_q;
	logic               v0_q, v1_q;
	wavp_pkg::div_req_t dreq;
	wavp_pkg::div_rsp_t drsp;
	logic        acc, pop;
	logic [31:0] tag_n, len_n;
	logic        is16;

	wavp_divider u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	assign s_tready = !v0_q && phase_q != wavp_pkg::PH_DIV;
	assign acc = s_tvalid && s_tready;
	assign pop = m_tvalid && m_tready;
	assign is16 = bits_q == 16'd16;
	assign tag_n = {tag_q[23:0], s_tdata};
	assign len_n = len_q | (32'(s_tdata) << {pos_q[1:0], 3'b000});

	// divider request for the frame count
	always_comb begin
		dreq.start    = 1'b0;
		dreq.dividend = len_n;
		dreq.divisor  = is16 ? {chans_q, 1'b0} : {1'b0, chans_q};
		if (acc && s_tuser == wavp_pkg::OP_BYTE && !finished_q &&
			phase_q == wavp_pkg::PH_CHUNK && pos_q == 4'd7 && tag_q == wavp_pkg::TAG_DATA &&
			fvalid_q && fmt_q == 16'd1 && chans_q != 16'd0 &&
			(bits_q == 16'd8 || is16))
			dreq.start = 1'b1;
	end

	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			wavp_pkg::PH_DIV: if (drsp.done) phase_d = wavp_pkg::PH_DATA;
			default: phase_d = phase_q;
		endcase
	end

	function automatic wavp_pkg::result_t mk(logic k, logic [15:0] s, logic [15:0] c,
		logic [15:0] n, logic [31:0] r, logic [2:0] st, logic l);
		wavp_pkg::result_t x;
		x.kind = k; x.sample = s; x.channel_index = c; x.channel_count = n;
		x.sample_rate = r; x.status = st; x.last = l;
		return x;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= wavp_pkg::PH_HEADER; pos_q <= '0; tag_q <= '0; len_q <= '0;
			skip_q <= '0; fmt_q <= '0; chans_q <= '0; rate_q <= '0; bits_q <= '0;
			fvalid_q <= 1'b0; remain_q <= '0; low_q <= '0; chan_cnt_q <= '0;
			finished_q <= 1'b0; v0_q <= 1'b0; v1_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			if (pop) begin
				v0_q <= v1_q; out0_q <= out1_q; v1_q <= 1'b0;
			end
			if (phase_q == wavp_pkg::PH_DIV && drsp.done)
				remain_q <= drsp.quotient * 32'(chans_q);
			if (phase_q == wavp_pkg::PH_DIV && drsp.done && drsp.quotient == 32'd0) begin
				v0_q <= 1'b1; finished_q <= 1'b1;
				out0_q <= mk(wavp_pkg::KIND_STATUS, '0, '0, chans_q, rate_q,
					wavp_pkg::ST_EMPTY, 1'b1);
			end
			if (acc) begin
				if (s_tuser == wavp_pkg::OP_EOF) begin
					if (!finished_q) begin
						v0_q <= 1'b1;
						out0_q <= mk(wavp_pkg::KIND_STATUS, '0, '0, chans_q, rate_q,
							phase_q == wavp_pkg::PH_HEADER ? wavp_pkg::ST_BAD_HDR :
							phase_q == wavp_pkg::PH_FMT ? wavp_pkg::ST_SHORT_FMT :
							wavp_pkg::ST_TRUNC, 1'b1);
					end
					phase_q <= wavp_pkg::PH_HEADER; pos_q <= '0; tag_q <= '0; len_q <= '0;
					skip_q <= '0; fmt_q <= '0; chans_q <= '0; rate_q <= '0; bits_q <= '0;
					fvalid_q <= 1'b0; remain_q <= '0; low_q <= '0; chan_cnt_q <= '0;
					finished_q <= 1'b0;
				end else if (!finished_q) begin
					case (phase_q)
						wavp_pkg::PH_HEADER: begin
							if ((pos_q < 4'd4 && s_tdata != wavp_pkg::TAG_RIFF[8*(3-pos_q[1:0]) +: 8])
								|| (pos_q >= 4'd8 &&
								s_tdata != wavp_pkg::TAG_WAVE[8*(3-pos_q[1:0]) +: 8])) begin
								v0_q <= 1'b1; finished_q <= 1'b1;
								out0_q <= mk(wavp_pkg::KIND_STATUS, '0, '0, chans_q, rate_q,
									wavp_pkg::ST_BAD_HDR, 1'b1);
							end else if (pos_q == 4'd11) begin
								phase_q <= wavp_pkg::PH_CHUNK; pos_q <= '0;
							end else pos_q <= pos_q + 4'd1;
						end
						wavp_pkg::PH_CHUNK: begin
							if (pos_q == 4'd0) begin
								tag_q <= {24'd0, s_tdata}; len_q <= '0;
							end else if (pos_q < 4'd4) tag_q <= tag_n;
							else len_q <= len_n;
							pos_q <= pos_q + 4'd1;
							if (pos_q == 4'd7) begin
								pos_q <= '0;
								if (tag_q == wavp_pkg::TAG_FMT) begin
									if (len_n < 32'd16) begin
										v0_q <= 1'b1; finished_q <= 1'b1;
										out0_q <= mk(wavp_pkg::KIND_STATUS, '0, '0, chans_q,
											rate_q, wavp_pkg::ST_SHORT_FMT, 1'b1);
									end else phase_q <= wavp_pkg::PH_FMT;
								end else if (tag_q == wavp_pkg::TAG_DATA) begin
									if (dreq.start) begin
										phase_q <= wavp_pkg::PH_DIV; chan_cnt_q <= '0;
									end else begin
										v0_q <= 1'b1; finished_q <= 1'b1;
										out0_q <= mk(wavp_pkg::KIND_STATUS, '0, '0, chans_q,
											rate_q, wavp_pkg::ST_UNSUPP, 1'b1);
									end
								end else begin
									skip_q <= 33'(len_n) + 33'(len_n[0]);
									phase_q <= (len_n == 32'd0) ? wavp_pkg::PH_CHUNK
										: wavp_pkg::PH_SKIP;
								end
							end
						end
						wavp_pkg::PH_FMT: begin
							case (pos_q)
								4'd0: fmt_q[7:0] <= s_tdata;
								4'd1: fmt_q[15:8] <= s_tdata;
								4'd2: chans_q[7:0] <= s_tdata;
								4'd3: chans_q[15:8] <= s_tdata;
								4'd4: rate_q[7:0] <= s_tdata;
								4'd5: rate_q[15:8] <= s_tdata;
								4'd6: rate_q[23:16] <= s_tdata;
								4'd7: rate_q[31:24] <= s_tdata;
								4'd14: bits_q[7:0] <= s_tdata;
								4'd15: bits_q[15:8] <= s_tdata;
								default: ;
							endcase
							pos_q <= pos_q + 4'd1;
							if (pos_q == 4'd15) begin
								fvalid_q <= 1'b1; pos_q <= '0;
								skip_q <= 33'(len_q - 32'd16);
								phase_q <= (len_q == 32'd16) ? wavp_pkg::PH_CHUNK
									: wavp_pkg::PH_SKIP;
							end
						end
						wavp_pkg::PH_SKIP: begin
							skip_q <= skip_q - 33'd1;
							if (skip_q == 33'd1) begin
								phase_q <= wavp_pkg::PH_CHUNK; pos_q <= '0;
							end
						end
						wavp_pkg::PH_DATA: begin
							if (is16 && pos_q == 4'd0) begin
								low_q <= s_tdata; pos_q <= 4'd1;
							end else begin
								pos_q <= '0;
								v0_q <= 1'b1;
								out0_q <= mk(wavp_pkg::KIND_SAMPLE,
									is16 ? {s_tdata, low_q} : {s_tdata ^ wavp_pkg::PCM_OFFSET, 8'd0},
									chan_cnt_q, chans_q, rate_q, wavp_pkg::ST_OK, 1'b0);
								chan_cnt_q <= (chan_cnt_q + 16'd1 >= chans_q) ? 16'd0
									: chan_cnt_q + 16'd1;
								remain_q <= remain_q - 32'd1;
								if (remain_q == 32'd1) begin
									v1_q <= 1'b1; finished_q <= 1'b1;
									out1_q <= mk(wavp_pkg::KIND_STATUS, '0, '0, chans_q,
										rate_q, wavp_pkg::ST_OK, 1'b1);
								end
							end
						end
						default: ;
					endcase
				end
			end
		end
	end

	assign m_tvalid = v0_q;
	assign m_tuser  = out0_q.kind;
	assign m_tlast  = out0_q.last;
	assign m_tdata  = {5'd0, out0_q.status, out0_q.sample_rate, out0_q.channel_count,
		out0_q.channel_index, out0_q.sample};

`ifndef ASSERT_OFF
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == wavp_pkg::PH_DIV |-> !s_tready) else $error("accept during divide");
	a_second_needs_first: assert property (@(posedge clk) disable iff (!arst_n)
		v1_q |-> v0_q) else $error("second result without first");
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == m_tlast)) else $error("last not on status");
`endif
endmodule

[tb/wav_pcm_stream_parser_tb.sv]
// Testbench for the WAV PCM stream parser: directed and random files against a scoreboard.
`timescale 1ns / 100ps

module wav_pcm_stream_parser_tb;

	// one expected or observed output transaction
	typedef struct packed {
		logic        kind;
		logic [15:0] sample;
		logic [15:0] chan;
		logic [15:0] nchan;
		logic [31:0] rate;
		logic [2:0]  status;
		logic        last;
	} wav_result_t;

	// Scoreboard: tracks parser state, predicts results per accepted byte, checks outputs.
	class wav_scoreboard;
		wavp_pkg::phase_t ph;
		logic [3:0]  pos;
		logic [31:0] tag, clen, rate, remaining;
		logic [32:0] skip;
		logic [15:0] fmt_code, nchan, bits, chan_ctr;
		logic [7:0]  lo;
		bit          fmt_ok, done;
		wav_result_t pending[$];
		int          errors, results_seen, samples_seen, files_seen, inputs_seen;

		function void clear();
			ph = wavp_pkg::PH_HEADER; pos = 0; tag = 0; clen = 0; skip = 0; fmt_code = 0;
			nchan = 0; rate = 0; bits = 0; fmt_ok = 0; remaining = 0; lo = 0;
			chan_ctr = 0; done = 0;
		endfunction

		function void push(logic k, logic [15:0] s, logic [15:0] c, wavp_pkg::status_t st,
				logic l);
			wav_result_t r;
			r.kind = k; r.sample = s; r.chan = c; r.nchan = nchan; r.rate = rate;
			r.status = st; r.last = l;
			pending.push_back(r);
		endfunction

		function void close_file(wavp_pkg::status_t st);
			push(wavp_pkg::KIND_STATUS, 16'd0, 16'd0, st, 1'b1);
			done = 1;
		endfunction

		// note an accepted input transaction
		function void note_input(logic op, logic [7:0] b);
			logic [63:0] per_frame, frames;
			logic [15:0] smp;
			inputs_seen++;
			if (op == wavp_pkg::OP_EOF) begin
				files_seen++;
				if (!done) begin
					if (ph == wavp_pkg::PH_HEADER) close_file(wavp_pkg::ST_BAD_HDR);
					else if (ph == wavp_pkg::PH_FMT) close_file(wavp_pkg::ST_SHORT_FMT);
					else close_file(wavp_pkg::ST_TRUNC);
				end
				clear();
				return;
			end
			if (done) return;
			case (ph)
				wavp_pkg::PH_HEADER: begin
					if ((pos < 4 && b != wavp_pkg::TAG_RIFF[31 - 8*pos -: 8]) ||
							(pos >= 8 && b != wavp_pkg::TAG_WAVE[31 - 8*(pos - 8) -: 8])) begin
						close_file(wavp_pkg::ST_BAD_HDR);
						return;
					end
					pos++;
					if (pos == 12) begin
						ph = wavp_pkg::PH_CHUNK; pos = 0;
					end
				end
				wavp_pkg::PH_CHUNK: begin
					if (pos == 0) begin
						tag = 0; clen = 0;
					end
					if (pos < 4) tag = {tag[23:0], b};
					else clen[8*(pos - 4) +: 8] = b;
					pos++;
					if (pos < 8) return;
					pos = 0;
					if (tag == wavp_pkg::TAG_FMT) begin
						if (clen < 16) close_file(wavp_pkg::ST_SHORT_FMT);
						else ph = wavp_pkg::PH_FMT;
					end else if (tag == wavp_pkg::TAG_DATA) begin
						if (!fmt_ok || fmt_code != 1 || nchan == 0 ||
								(bits != 8 && bits != 16)) begin
							close_file(wavp_pkg::ST_UNSUPP);
							return;
						end
						per_frame = 64'(bits / 16'd8) * 64'(nchan);
						frames = 64'(clen) / per_frame;
						if (frames == 0) begin
							close_file(wavp_pkg::ST_EMPTY);
							return;
						end
						remaining = 32'(frames * 64'(nchan));
						chan_ctr = 0;
						ph = wavp_pkg::PH_DATA;
					end else begin
						skip = {1'b0, clen} + 33'(clen[0]);
						ph = (skip != 0) ? wavp_pkg::PH_SKIP : wavp_pkg::PH_CHUNK;
					end
				end
				wavp_pkg::PH_FMT: begin
					case (pos)
						0: fmt_code[7:0] = b;
						1: fmt_code[15:8] = b;
						2: nchan[7:0] = b;
						3: nchan[15:8] = b;
						4, 5, 6, 7: rate[8*(pos - 4) +: 8] = b;
						14: bits[7:0] = b;
						15: bits[15:8] = b;
						default: ;
					endcase
					if (pos == 15) begin
						fmt_ok = 1; pos = 0;
						skip = {1'b0, clen} - 33'd16;
						ph = (skip != 0) ? wavp_pkg::PH_SKIP : wavp_pkg::PH_CHUNK;
					end else pos++;
				end
				wavp_pkg::PH_SKIP: begin
					if (skip != 0) skip--;
					if (skip == 0) begin
						ph = wavp_pkg::PH_CHUNK; pos = 0;
					end
				end
				default: begin // sample data
					if (bits == 16) begin
						if (pos == 0) begin
							lo = b; pos = 1;
							return;
						end
						smp = {b, lo};
						pos = 0;
					end else smp = {b ^ 8'h80, 8'h00};
					push(wavp_pkg::KIND_SAMPLE, smp, chan_ctr, wavp_pkg::ST_OK, 1'b0);
					samples_seen++;
					chan_ctr++;
					if (chan_ctr >= nchan) chan_ctr = 0;
					if (remaining != 0) remaining--;
					if (remaining == 0) close_file(wavp_pkg::ST_OK);
				end
			endcase
		endfunction

		// compare one accepted output transaction with the oldest expectation
		function void check_result(wav_result_t got);
			wav_result_t want;
			results_seen++;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("ERROR: unexpected result kind=%0d status=%0d",
					got.kind, got.status);
				return;
			end
			want = pending.pop_front();
			if (got != want) begin
				errors++;
				if (errors <= 10) begin
					$display("ERROR: exp k%0d s%h c%0d n%0d r%0d st%0d l%0d",
						want.kind, want.sample, want.chan, want.nchan, want.rate, want.status,
						want.last);
					$display("       got k%0d s%h c%0d n%0d r%0d st%0d l%0d",
						got.kind, got.sample, got.chan, got.nchan, got.rate,
						got.status, got.last);
				end
			end
		endfunction
	endclass

	logic        clk, arst_n;
	logic        s_tvalid, s_tready, s_tuser;
	logic [7:0]  s_tdata;
	logic        m_tvalid, m_tready, m_tuser, m_tlast;
	logic [87:0] m_tdata;

	wav_scoreboard sb;
	int idle_cycles;
	bit stall_mode;

	// file under construction: opcode is bit 8
	logic [8:0] file_q[$];

	wav_pcm_stream_parser u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// output side: sample on rising edge, stall pattern changed at falling edge
	always @(posedge clk) begin
		wav_result_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.sample = m_tdata[15:0];
			got.chan   = m_tdata[31:16];
			got.nchan  = m_tdata[47:32];
			got.rate   = m_tdata[79:48];
			got.status = m_tdata[82:80];
			got.kind   = m_tuser;
			got.last   = m_tlast;
			sb.check_result(got);
		end
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles > 4000) begin
			$display("Timeout: no transaction for 4000 cycles");
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// receiver stalls: phases with and without back-pressure
	always @(negedge clk) begin
		if ($urandom_range(0, 99) == 0) stall_mode = ~stall_mode;
		if (stall_mode) m_tready <= ($urandom_range(0, 3) != 0);
		else m_tready <= 1'b1;
	end

	function void put_byte(logic [7:0] b);
		file_q.push_back({wavp_pkg::OP_BYTE, b});
	endfunction

	function void put_word(logic [31:0] w, int n); // little-endian
		for (int i = 0; i < n; i++) put_byte(w[8*i +: 8]);
	endfunction

	function void put_tag(logic [31:0] t);
		for (int i = 3; i >= 0; i--) put_byte(t[8*i +: 8]);
	endfunction

	function void put_header();
		put_tag(wavp_pkg::TAG_RIFF);
		put_word($urandom, 4);
		put_tag(wavp_pkg::TAG_WAVE);
	endfunction

	function void put_fmt(int extra, int code, int ch, logic [31:0] r, int bps);
		put_tag(wavp_pkg::TAG_FMT);
		put_word(16 + extra, 4);
		put_word(code, 2); put_word(ch, 2); put_word(r, 4);
		put_word($urandom, 4); put_word($urandom, 2); put_word(bps, 2);
		for (int i = 0; i < extra; i++) put_byte(8'($urandom));
	endfunction

	function void put_eof();
		file_q.push_back({wavp_pkg::OP_EOF, 8'($urandom)});
	endfunction

	// send the queued file in bursts with random gaps
	task automatic send_file();
		int burst;
		burst = 0;
		while (file_q.size() != 0) begin
			if (burst == 0) begin
				burst = $urandom_range(1, 20);
				if ($urandom_range(0, 2) == 0) begin
					s_tvalid <= 1'b0;
					repeat ($urandom_range(1, 6)) @(negedge clk);
				end
			end
			s_tvalid <= 1'b1;
			s_tuser  <= file_q[0][8];
			s_tdata  <= file_q[0][7:0];
			@(posedge clk);
			while (!s_tready) @(posedge clk);
			sb.note_input(file_q[0][8], file_q[0][7:0]);
			void'(file_q.pop_front());
			burst--;
			@(negedge clk);
		end
		s_tvalid <= 1'b0;
		@(negedge clk);
	endtask

	// build a random, mostly well-formed file
	function void build_random_file();
		int kind_sel, frames, ch, bps, dlen;
		kind_sel = $urandom_range(0, 19);
		if (kind_sel == 0) begin // noise
			repeat ($urandom_range(1, 15)) put_byte(8'($urandom));
			put_eof();
			return;
		end
		put_header();
		if ($urandom_range(0, 3) == 0) begin // unknown chunk, odd or even
			dlen = $urandom_range(0, 5);
			put_tag($urandom); put_word(dlen, 4);
			repeat (dlen + dlen % 2) put_byte(8'($urandom));
		end
		ch  = $urandom_range(1, 3);
		bps = $urandom_range(0, 1) ? 16 : 8;
		if (kind_sel == 1) put_fmt(0, $urandom_range(0, 3), $urandom_range(0, 2), $urandom,
			$urandom_range(0, 1) ? 24 : 8);
		else if (kind_sel == 2) begin // short fmt
			put_tag(wavp_pkg::TAG_FMT); put_word($urandom_range(0, 15), 4);
		end else put_fmt($urandom_range(0, 3), 1, ch, $urandom, bps);
		frames = $urandom_range(0, 6);
		dlen = frames * ch * bps / 8 + $urandom_range(0, 1);
		put_tag(wavp_pkg::TAG_DATA); put_word(dlen, 4);
		repeat (kind_sel == 3 ? dlen / 2 : dlen) put_byte(8'($urandom));
		if ($urandom_range(0, 3) == 0) repeat (3) put_byte(8'($urandom));
		put_eof();
	endfunction

	initial begin
		sb = new();
		sb.clear();
		s_tvalid = 0; s_tuser = 0; s_tdata = 0; m_tready = 1; stall_mode = 0;
		idle_cycles = 0;
		arst_n = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: bad header, then a 16-bit stereo clip with extreme samples
		put_byte(8'h00); put_eof(); put_eof();
		put_header();
		put_fmt(2, 1, 2, 32'hFFFF_FFFF, 16);
		put_tag(wavp_pkg::TAG_DATA); put_word(32'd9, 4);
		put_word(32'h0000_8000, 2); put_word(32'h0000_7FFF, 2);
		put_word(32'h0000_FFFF, 2); put_word(32'h0000_0000, 2);
		put_byte(8'hFF); put_eof();
		send_file();
		// directed: 8-bit mono extremes, no fmt (unsupported), empty data
		put_header();
		put_fmt(0, 1, 1, 32'd0, 8);
		put_tag(wavp_pkg::TAG_DATA); put_word(32'd3, 4);
		put_byte(8'h00); put_byte(8'hFF); put_byte(8'h80); put_eof();
		put_header(); put_tag(wavp_pkg::TAG_DATA); put_word(32'd4, 4); put_eof();
		put_header(); put_fmt(0, 1, 65535, 32'd1, 16);
		put_tag(wavp_pkg::TAG_DATA); put_word(32'd5, 4); put_eof();
		send_file();

		// hold off until all outstanding results have drained
		while (sb.pending.size() != 0) @(negedge clk);

		while (sb.inputs_seen < 550) begin
			build_random_file();
			send_file();
		end

		while (sb.pending.size() != 0) @(negedge clk);
		repeat (50) @(negedge clk);
		$display("Covered %0d input bytes in %0d files, %0d results, %0d samples.",
			sb.inputs_seen, sb.files_seen, sb.results_seen, sb.samples_seen);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
